// ===== design/pairwise_series_integrator_defines.svh =====
// Assertion macros shared by the pairwise series integrator RTL.
`ifndef PAIRWISE_SERIES_INTEGRATOR_DEFINES_SVH
`define PAIRWISE_SERIES_INTEGRATOR_DEFINES_SVH

// cond must hold at every clock edge out of reset
`define PSI_ASSERT_HOLDS(label, c, r, cond, msg) \
  label: assert property (@(posedge c) disable iff (!r) (cond)) \
    else $error(msg);

// ante implies cons in the same cycle
`define PSI_ASSERT_IMP(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define PSI_ASSERT_NXT(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/psi_pkg.sv =====
// Types, codes and fixed widths of the pairwise series integrator.
`default_nettype none

package psi_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int METHOD_W   = 3;

  // interval weight in quarters of y, and exact dx
  localparam int SUM_W      = DATA_W + 3;
  localparam int DX_W       = DATA_W + 1;

  // multiplier operands and product
  localparam int MA_W       = 64;
  localparam int MB_W       = DX_W;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int DIGIT_W    = 16;
  localparam int NDIG       = (MB_W + DIGIT_W - 1) / DIGIT_W;
  localparam int BPAD_W     = NDIG * DIGIT_W;

  localparam int JOBQ_DEPTH = 2;

  localparam logic [METHOD_W-1:0] METH_RECT   = 3'd0;
  localparam logic [METHOD_W-1:0] METH_RECT_C = 3'd1;
  localparam logic [METHOD_W-1:0] METH_TRAP   = 3'd2;
  localparam logic [METHOD_W-1:0] METH_TRAP_A = 3'd3;
  localparam logic [METHOD_W-1:0] METH_TRAP_B = 3'd4;
  localparam logic [METHOD_W-1:0] METH_PRE    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP  = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_value;
    logic                     series_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_x;
    logic signed [DATA_W-1:0] result_value;
    logic                     result_last;
  } out_item_t;

  typedef struct packed {
    logic                     pre;
    logic signed [DATA_W-1:0] x_out;
    logic                     last;
    logic signed [SUM_W-1:0]  s;
    logic signed [DX_W-1:0]   dx;
  } job_t;

  typedef struct packed {
    logic                   start;
    logic                   pass1;
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic signed [MA_W-1:0] result;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ===== design/psi_front.sv =====
// Front end: tracks the previous point and turns points into multiply jobs.
`default_nettype none

module psi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [psi_pkg::METHOD_W-1:0]     method,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  psi_pkg::in_item_t                in_item,
  output logic                             job_valid,
  input  logic                             job_ready,
  output psi_pkg::job_t                    job
);
  import psi_pkg::*;

  localparam logic [DATA_W-1:0] ONE_FX = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [DATA_W-1:0] prev_x_r, prev_y_r;
  logic                     have_prev_r, have_prev_nxt;
  logic                     first_r, first_nxt;
  logic                     accept, is_pre, is_pair, last;
  logic signed [SUM_W-1:0]  y1, y2, sum, base, extra, s_pair, s_pre;
  logic signed [DX_W-1:0]   dx;

  assign in_ready = job_ready;
  assign accept   = in_valid & in_ready;
  assign last     = in_item.series_end;

  assign y1    = $signed({{(SUM_W-DATA_W){prev_y_r[DATA_W-1]}}, prev_y_r});
  assign y2    = $signed({{(SUM_W-DATA_W){in_item.point_value[DATA_W-1]}},
                          in_item.point_value});
  assign s_pre = y2;
  assign sum   = y1 + y2;
  assign dx    = $signed({in_item.point_x[DATA_W-1], in_item.point_x})
               - $signed({prev_x_r[DATA_W-1], prev_x_r});

  always_comb begin
    if ((method == METH_RECT) || (method == METH_RECT_C)) begin
      base = y1 <<< 2;
    end else begin
      base = sum <<< 1;
    end
    extra = '0;
    priority if (method == METH_TRAP_A) begin
      // end terms: both at once on a single interval
      priority if (first_r && last) extra = sum <<< 1;
      else if (first_r)             extra = y1 <<< 1;
      else if (last)                extra = y2 <<< 1;
      else                          extra = '0;
    end else if (method == METH_TRAP_B) begin
      if (first_r || last) extra = sum;
    end else begin
      extra = '0;
    end
  end

  assign s_pair = base + extra;

  assign is_pre  = (method == METH_PRE);
  assign is_pair = have_prev_r && (method <= METH_TRAP_B);

  assign job_valid = in_valid & (is_pre | is_pair);
  assign job.pre   = is_pre;
  assign job.x_out = is_pre ? $signed(ONE_FX) : prev_x_r;
  assign job.last  = last;
  assign job.s     = is_pre ? s_pre : s_pair;
  assign job.dx    = dx;

  always_comb begin
    have_prev_nxt = have_prev_r;
    first_nxt     = first_r;
    if (accept) begin
      if (last) begin
        have_prev_nxt = 1'b0;
        first_nxt     = 1'b1;
      end else begin
        first_nxt     = ~have_prev_r;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      first_r     <= 1'b1;
    end else begin
      have_prev_r <= have_prev_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x_r <= in_item.point_x;
      prev_y_r <= in_item.point_value;
    end
  end

endmodule

`default_nettype wire

// ===== design/psi_fifo.sv =====
// Short job queue between the front end and the multiply back end.
`default_nettype none
`include "pairwise_series_integrator_defines.svh"

module psi_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  psi_pkg::job_t din,
  output logic          pop_valid,
  input  logic          pop_ready,
  output psi_pkg::job_t dout
);
  import psi_pkg::*;

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(JOBQ_DEPTH - 1);
  localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(JOBQ_DEPTH);

  job_t             mem_r [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             push_en, pop_en;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign push_en    = push_valid & push_ready;
  assign pop_en     = pop_valid & pop_ready;
  assign dout       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_en) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop_en)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push_en && !pop_en)      count_nxt = count_r + 1'b1;
    else if (pop_en && !push_en) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) mem_r[wr_ptr_r] <= din;
  end

  `PSI_ASSERT_HOLDS(a_fifo_cnt_max, clk, rst_n, count_r <= FULL_CNT, "job queue overfilled")
  `PSI_ASSERT_NXT(a_fifo_cnt_up, clk, rst_n, push_en && !pop_en, count_r == $past(count_r) + 1, "job queue count lost a push")

endmodule

`default_nettype wire

// ===== design/psi_mul.sv =====
// Digit-serial signed multiply with round-half-up scaling and saturation.
`default_nettype none
`include "pairwise_series_integrator_defines.svh"

module psi_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psi_pkg::mul_req_t req,
  output psi_pkg::mul_rsp_t rsp
);
  import psi_pkg::*;

  localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(NDIG - 1);
  localparam logic [PROD_W-1:0] HALF_P1  = {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
  localparam logic [PROD_W-1:0] HALF_P2  = {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    MS_IDLE = 4'b0001,
    MS_MUL  = 4'b0010,
    MS_RND  = 4'b0100,
    MS_SAT  = 4'b1000
  } mul_state_t;

  mul_state_t               state_r, state_nxt;
  logic [MA_W-1:0]          mag_a_r, mag_a;
  logic [BPAD_W-1:0]        b_sh_r;
  logic [MB_W-1:0]          mag_b;
  logic                     neg_r, pass1_r, done_r, done_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic [PROD_W-1:0]        acc_r, acc_mul, acc_rnd, half;
  logic [MA_W+DIGIT_W-1:0]  pp;
  logic signed [PROD_W-1:0] q1, q2;
  logic                     fit64, fitd;
  logic [MA_W-1:0]          v64, vd_ext;
  logic [DATA_W-1:0]        vd;
  logic signed [MA_W-1:0]   res_r;

  assign mag_a = req.a[MA_W-1] ? (~req.a + 1'b1) : req.a;
  assign mag_b = req.b[MB_W-1] ? (~req.b + 1'b1) : req.b;

  // most significant digit first: acc = acc * 2^DIGIT_W + |a| * digit
  assign pp      = mag_a_r * b_sh_r[BPAD_W-1 -: DIGIT_W];
  assign acc_mul = {acc_r[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                 + {{(PROD_W-MA_W-DIGIT_W){1'b0}}, pp};

  // apply sign and rounding offset in one add: -p + h = ~p + h + 1
  assign half    = pass1_r ? HALF_P1 : HALF_P2;
  assign acc_rnd = (neg_r ? ~acc_r : acc_r) + half + {{(PROD_W-1){1'b0}}, neg_r};

  assign q1    = $signed(acc_r) >>> (FRAC_BITS + 2);
  assign q2    = $signed(acc_r) >>> FRAC_BITS;
  assign fit64 = (&q1[PROD_W-1:MA_W-1]) | ~(|q1[PROD_W-1:MA_W-1]);
  assign fitd  = (&q2[PROD_W-1:DATA_W-1]) | ~(|q2[PROD_W-1:DATA_W-1]);
  assign v64   = fit64 ? q1[MA_W-1:0]
               : (q1[PROD_W-1] ? {1'b1, {(MA_W-1){1'b0}}} : {1'b0, {(MA_W-1){1'b1}}});
  assign vd    = fitd ? q2[DATA_W-1:0]
               : (q2[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
  assign vd_ext = {{(MA_W-DATA_W){vd[DATA_W-1]}}, vd};

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      MS_IDLE: if (req.start) state_nxt = MS_MUL;
      MS_MUL:  if (cnt_r == CNT_LAST) state_nxt = MS_RND;
      MS_RND:  state_nxt = MS_SAT;
      MS_SAT: begin
        state_nxt = MS_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MS_IDLE: begin
        if (req.start) begin
          mag_a_r <= mag_a;
          b_sh_r  <= {{(BPAD_W-MB_W){1'b0}}, mag_b};
          neg_r   <= req.a[MA_W-1] ^ req.b[MB_W-1];
          pass1_r <= req.pass1;
          cnt_r   <= '0;
          acc_r   <= '0;
        end
      end
      MS_MUL: begin
        acc_r  <= acc_mul;
        b_sh_r <= {b_sh_r[BPAD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        cnt_r  <= cnt_r + 1'b1;
      end
      MS_RND: acc_r <= acc_rnd;
      MS_SAT: res_r <= $signed(pass1_r ? v64 : vd_ext);
      default: ;
    endcase
  end

  assign rsp.busy   = (state_r != MS_IDLE);
  assign rsp.done   = done_r;
  assign rsp.result = res_r;

  `PSI_ASSERT_IMP(a_mul_start_idle, clk, rst_n, req.start, state_r == MS_IDLE, "multiply started while busy")
  `PSI_ASSERT_NXT(a_mul_done_pulse, clk, rst_n, rsp.done, !rsp.done, "multiply done held longer than a cycle")

endmodule

`default_nettype wire

// ===== design/psi_back.sv =====
// Back end: runs each job through one or two multiply passes into the output word.
`default_nettype none
`include "pairwise_series_integrator_defines.svh"

module psi_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [psi_pkg::DATA_W-1:0] recip,
  input  logic                            job_valid,
  output logic                            job_ready,
  input  psi_pkg::job_t                   job,
  output psi_pkg::mul_req_t               mreq,
  input  psi_pkg::mul_rsp_t               mrsp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output psi_pkg::out_item_t              out_item
);
  import psi_pkg::*;

  typedef enum logic [3:0] {
    BS_IDLE = 4'b0001,
    BS_P1   = 4'b0010,
    BS_P2   = 4'b0100,
    BS_HOLD = 4'b1000
  } back_state_t;

  back_state_t              state_r, state_nxt;
  logic signed [DATA_W-1:0] x_r;
  logic                     last_r;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r;
  logic                     out_free, load_out, pop;
  logic signed [MB_W-1:0]   recip_ext;

  assign recip_ext = $signed({{(MB_W-DATA_W){recip[DATA_W-1]}}, recip});
  assign out_free  = ~out_valid_r | out_ready;
  assign pop       = job_valid & job_ready;

  always_comb begin
    state_nxt = state_r;
    job_ready = 1'b0;
    load_out  = 1'b0;
    mreq      = '0;
    unique case (state_r)
      BS_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          mreq.start = 1'b1;
          mreq.pass1 = ~job.pre;
          mreq.a     = $signed({{(MA_W-SUM_W){job.s[SUM_W-1]}}, job.s});
          mreq.b     = job.pre ? recip_ext : job.dx;
          state_nxt  = job.pre ? BS_P2 : BS_P1;
        end
      end
      BS_P1: begin
        // interval contribution done; scale it by the reciprocal
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.pass1 = 1'b0;
          mreq.a     = mrsp.result;
          mreq.b     = recip_ext;
          state_nxt  = BS_P2;
        end
      end
      BS_P2: begin
        if (mrsp.done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = BS_IDLE;
          end else begin
            state_nxt = BS_HOLD;
          end
        end
      end
      BS_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r    <= job.x_out;
      last_r <= job.last;
    end
    if (load_out) begin
      out_item_r.result_x     <= x_r;
      out_item_r.result_value <= mrsp.result[DATA_W-1:0];
      out_item_r.result_last  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PSI_ASSERT_IMP(a_back_mul_alive, clk, rst_n, (state_r == BS_P1) || (state_r == BS_P2), mrsp.busy || mrsp.done, "back end waits on an idle multiplier")

endmodule

`default_nettype wire

// ===== design/pairwise_series_integrator.sv =====
// Pairwise series integrator top level: config registers, front end, job queue, back end.
//
// Usage:
//   in_valid/in_ready/in_item carry one (x, y, series_end) sample point per word.
//   out_valid/out_ready/out_item carry one result word: left x of the interval
//   (or 1.0 in preweighted mode), the normalized contribution, and the series
//   end mark of the point that caused it.
//   cfg_wr_en/cfg_index/cfg_data write method (index 0) or norm_reciprocal
//   (index 1); write only while the block is idle.
// Throughput: points are taken one per cycle while the two-entry job queue has
//   room. Each job runs on one shared 64x16 digit-serial multiplier; an interval
//   job takes two passes and a preweighted job one. Points that give no result
//   (first point of a series, unused method codes) make no job.
// Reset: no point held, method trapezoid, reciprocal 1.0, output empty.
// Stall: a result waits in the output register while out_ready is low; the
//   back end finishes the next job and holds it, and the queue keeps filling.
`default_nettype none

module pairwise_series_integrator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  psi_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output psi_pkg::out_item_t                 out_item,
  input  logic                               cfg_wr_en,
  input  logic [psi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import psi_pkg::*;

  localparam logic [DATA_W-1:0] ONE_FX = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [METHOD_W-1:0]      method_r, method_nxt;
  logic signed [DATA_W-1:0] recip_r, recip_nxt;

  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  job_t     fq_job, qb_job;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  always_comb begin
    method_nxt = method_r;
    recip_nxt  = recip_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_METHOD: method_nxt = cfg_data[METHOD_W-1:0];
        CFG_RECIP:  recip_nxt  = $signed(cfg_data[DATA_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= METH_TRAP;
      recip_r  <= $signed(ONE_FX);
    end else begin
      method_r <= method_nxt;
      recip_r  <= recip_nxt;
    end
  end

  psi_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .method    (method_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  psi_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .din        (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .dout       (qb_job)
  );

  psi_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  psi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .recip     (recip_r),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .mreq      (mreq),
    .mrsp      (mrsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
